>>> rtl/nddi_pkg.sv
// shared constants, codes and saturation helpers for the divided-difference interpolator
`timescale 1ns / 1ps
package nddi_pkg;
    localparam int DEF_MAX_NODES = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int ERR_W   = 2;
    localparam int ODATA_W = 40;
    localparam int PADDR_W = 3;

    localparam logic [PADDR_W-1:0] REG_EVAL_POINT = 3'd0;

    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DUP  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DROP = 2'd2;

    typedef logic signed [DATA_W-1:0] t_word;

    function automatic t_word sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_word sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return v[31:0];
    endfunction
endpackage

>>> rtl/newton_divided_difference_interp_core.sv
// top level: node store, in-place divided-difference builder and Newton-form evaluator
`timescale 1ns / 1ps
// Newton divided-difference interpolator.
// Slave stream: s_tdata = {node_y, node_x}, s_tlast marks the final node of a run.
// Each node is written into the x and coefficient memories as it is accepted; nodes past
// MAX_NODES are dropped and flagged. The last node starts the run and s_tready stays
// low until the run's results have all been handed to the output register.
// The coefficient build visits n*(n-1)/2 entries; each steps through S_CHK, S_RA, S_RB
// and S_RC, then through one pass of the shared divider unless the abscissae match,
// so the divider dominates the build time of a run.
// Evaluation then steps through S_ER, S_EA, S_EB, S_EC and S_EO per coefficient.
// Master stream: n coefficient results (m_tuser = 0) then the interpolated value
// (m_tuser = 1, m_tlast = 1). A stalled receiver holds the output register and the
// sequencer waits; no result is lost.
// Error code on every result of a run: 1 on a repeated abscissa, else 2 on dropped
// nodes, else 0.
// eval_point is set over the APB port at byte address 0.
// Reset clears the node count, error flags, eval_point and both handshakes;
// memory contents are left as they are.
module newton_divided_difference_interp_core #(
    parameter int MAX_NODES = nddi_pkg::DEF_MAX_NODES,
    parameter int FRAC_BITS = nddi_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,   // node_x [31:0], node_y [63:32]
    input  logic                               s_tlast,   // node_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nddi_pkg::ODATA_W-1:0]       m_tdata,   // coef_index, result_value, error_code
    output logic                               m_tuser,   // item_kind
    output logic                               m_tlast,   // result_last
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nddi_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_RA    = 4'd2;
    localparam logic [3:0] S_RB    = 4'd3;
    localparam logic [3:0] S_RC    = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_EINIT = 4'd6;
    localparam logic [3:0] S_ER    = 4'd7;
    localparam logic [3:0] S_EA    = 4'd8;
    localparam logic [3:0] S_EB    = 4'd9;
    localparam logic [3:0] S_EC    = 4'd10;
    localparam logic [3:0] S_EO    = 4'd11;
    localparam logic [3:0] S_EF    = 4'd12;

    nddi_pkg::t_word x_mem [MAX_NODES];
    nddi_pkg::t_word c_mem [MAX_NODES];

    logic [3:0]            r_state;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [1:0]            r_err;
    nddi_pkg::t_word       r_eval;
    nddi_pkg::t_word       r_c_rd;
    nddi_pkg::t_word       r_x_rd;
    nddi_pkg::t_word       r_cj;
    nddi_pkg::t_word       r_xj;
    nddi_pkg::t_word       r_cv;
    nddi_pkg::t_word       r_acc;
    nddi_pkg::t_word       r_prod;
    nddi_pkg::t_word       r_dq;
    logic signed [63:0]    r_mp;
    logic                  r_ov;
    logic [nddi_pkg::ODATA_W-1:0] r_od;
    logic                  r_ou;
    logic                  r_ol;

    logic                  w_acc_in;
    logic                  w_out_free;
    logic                  w_c_we;
    logic [AW-1:0]         w_c_wa;
    nddi_pkg::t_word       w_c_wd;
    logic                  w_x_we;
    logic [AW-1:0]         w_c_ra;
    logic [AW-1:0]         w_x_ra;
    logic [CW-1:0]         w_cnt_n;
    nddi_pkg::t_word       w_num;
    nddi_pkg::t_word       w_den;
    logic                  w_div_start;
    logic                  w_div_busy;
    logic                  w_div_done;
    nddi_pkg::t_word       w_quot;
    logic [nddi_pkg::ERR_W-1:0] w_ecode;
    nddi_pkg::t_word       w_term;
    logic                  w_load_out;
    logic [nddi_pkg::IDX_W-1:0] w_idx;
    logic [CW-1:0]         w_jm;

    assign w_acc_in   = s_tvalid && s_tready;
    assign w_out_free = !r_ov || m_tready;
    assign s_tready   = (r_state == S_LOAD);
    assign w_cnt_n    = (r_cnt < CW'(MAX_NODES)) ? r_cnt + 1'b1 : r_cnt;
    assign w_jm       = r_j - 1'b1;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == nddi_pkg::REG_EVAL_POINT) ? 32'(r_eval) : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == nddi_pkg::REG_EVAL_POINT) begin
            r_eval <= pwdata;
        end
    end

    // memory ports
    assign w_x_we = w_acc_in && (r_cnt < CW'(MAX_NODES));
    always_comb begin
        w_c_we = 1'b0;
        w_c_wa = r_j[AW-1:0];
        w_c_wd = w_quot;
        if (r_state == S_LOAD) begin
            w_c_we = w_x_we;
            w_c_wa = r_cnt[AW-1:0];
            w_c_wd = s_tdata[63:32];
        end else if (r_state == S_RC && w_den == '0) begin
            w_c_we = 1'b1;
            w_c_wd = '0;
        end else if (r_state == S_DIV && w_div_done) begin
            w_c_we = 1'b1;
        end
    end

    always_comb begin
        w_c_ra = r_j[AW-1:0];
        w_x_ra = r_j[AW-1:0];
        if (r_state == S_RB) begin
            w_c_ra = w_jm[AW-1:0];
            w_x_ra = AW'(w_jm - r_i);
        end else if (r_state == S_ER) begin
            w_c_ra = r_i[AW-1:0];
            w_x_ra = r_i[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            c_mem[w_c_wa] <= w_c_wd;
        end
        r_c_rd <= c_mem[w_c_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_x_we) begin
            x_mem[r_cnt[AW-1:0]] <= s_tdata[31:0];
        end
        r_x_rd <= x_mem[w_x_ra];
    end

    // divided-difference operands
    assign w_num       = nddi_pkg::sat33(33'(r_cj) - 33'(r_c_rd));
    assign w_den       = nddi_pkg::sat33(33'(r_xj) - 33'(r_x_rd));
    assign w_div_start = (r_state == S_RC) && (w_den != '0);

    nddi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_ecode = r_err[0] ? nddi_pkg::ERR_DUP
                   : (r_err[1] ? nddi_pkg::ERR_DROP : nddi_pkg::ERR_OK);
    assign w_term  = nddi_pkg::sat64(r_mp >>> FRAC_BITS);
    assign w_idx   = nddi_pkg::IDX_W'(r_i);
    assign w_load_out = ((r_state == S_EO) || (r_state == S_EF)) && w_out_free;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_err   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc_in) begin
                        r_cnt <= w_cnt_n;
                        if (r_cnt >= CW'(MAX_NODES)) begin
                            r_err[1] <= 1'b1;
                        end
                        if (s_tlast) begin
                            r_n     <= w_cnt_n;
                            r_i     <= '0;
                            r_j     <= w_cnt_n - 1'b1;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    priority if ({1'b0, r_i} + 1'b1 >= {1'b0, r_n}) begin
                        r_state <= S_EINIT;
                    end else if (r_j > r_i) begin
                        r_state <= S_RA;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_n - 1'b1;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: r_state <= S_RC;
                S_RC: begin
                    if (w_den == '0) begin
                        r_err[0] <= 1'b1;
                        r_j      <= w_jm;
                        r_state  <= S_CHK;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_j     <= w_jm;
                        r_state <= S_CHK;
                    end
                end
                S_EINIT: begin
                    r_i     <= '0;
                    r_state <= S_ER;
                end
                S_ER: r_state <= S_EA;
                S_EA: r_state <= S_EB;
                S_EB: r_state <= S_EC;
                S_EC: r_state <= S_EO;
                S_EO: begin
                    if (w_out_free) begin
                        if ({1'b0, r_i} + 1'b1 == {1'b0, r_n}) begin
                            r_state <= S_EF;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_ER;
                        end
                    end
                end
                S_EF: begin
                    if (w_out_free) begin
                        r_cnt   <= '0;
                        r_err   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_RB) begin
            r_cj <= r_c_rd;
            r_xj <= r_x_rd;
        end
        if (r_state == S_EINIT) begin
            r_acc  <= '0;
            r_prod <= nddi_pkg::t_word'(64'sd1 <<< FRAC_BITS);
        end
        if (r_state == S_EA) begin
            r_cv <= r_c_rd;
            r_mp <= 64'(r_c_rd) * 64'(r_prod);
            r_dq <= nddi_pkg::sat33(33'(r_eval) - 33'(r_x_rd));
        end
        if (r_state == S_EB) begin
            r_acc <= nddi_pkg::sat33(33'(r_acc) + 33'(w_term));
            r_mp  <= 64'(r_prod) * 64'(r_dq);
        end
        if (r_state == S_EC) begin
            r_prod <= w_term;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_state == S_EF) begin
                r_od <= {2'b00, w_ecode, 32'(r_acc), 4'd0};
                r_ou <= nddi_pkg::KIND_VALUE;
                r_ol <= 1'b1;
            end else begin
                r_od <= {2'b00, w_ecode, 32'(r_cv), w_idx};
                r_ou <= nddi_pkg::KIND_COEF;
                r_ol <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_od;
    assign m_tuser  = r_ou;
    assign m_tlast  = r_ol;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_NODES))
        else $error("node count exceeds store depth");
    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still accepted after the final node");
    a_last_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser == nddi_pkg::KIND_VALUE)
        else $error("final result is not the interpolated value");
    a_div_only_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> r_state == S_DIV)
        else $error("divider running outside the coefficient build");
endmodule

>>> rtl/nddi_div.sv
// sequential signed fixed-point divider, one quotient bit per cycle, saturated result
`timescale 1ns / 1ps
module nddi_div #(
    parameter int FRAC_BITS = nddi_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  nddi_pkg::t_word     i_num,
    input  nddi_pkg::t_word     i_den,
    output logic                o_busy,
    output logic                o_done,
    output nddi_pkg::t_word     o_quot
);
    localparam int DW  = 32 + FRAC_BITS;
    localparam int CNW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNW-1:0]  r_cnt;
    logic [DW-1:0]   r_dvd;
    logic [31:0]     r_rem;
    logic [31:0]     r_dmag;
    logic            r_neg;

    logic [32:0]     w_rem_sh;
    logic            w_qbit;
    logic [31:0]     w_nmag;
    logic signed [DW:0]  w_qs;
    logic signed [63:0]  w_qx;

    assign w_nmag   = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_rem_sh = {r_rem, r_dvd[DW-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd  <= {w_nmag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dmag <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_neg  <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= w_qbit ? 32'(w_rem_sh - {1'b0, r_dmag}) : w_rem_sh[31:0];
            r_dvd <= {r_dvd[DW-2:0], w_qbit};
        end
    end

    assign w_qs   = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
    assign w_qx   = 64'(w_qs);
    assign o_quot = nddi_pkg::sat64(w_qx);
    assign o_busy = r_busy;
    assign o_done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a running division");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(DW))
        else $error("divider step count out of range");
endmodule
